/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// Clocked on clk_i; the reset-gated form disables on rst_ni low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define SRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define SRF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`endif

/* design/srf_pkg.sv */
// Shared types and constants of the span resample filter.
// No dependencies; imported by every module of the block.
package srf_pkg;

  typedef logic [31:0] srf_pixel_t;  // red in [7:0] .. alpha in [31:24]

  typedef enum logic [1:0] {
    KIND_HALF,
    KIND_DBL_LEFT,
    KIND_DBL_RIGHT,
    KIND_SHARP
  } srf_kind_e;

  localparam logic [1:0] MODE_HALVE   = 2'd0;
  localparam logic [1:0] MODE_DOUBLE  = 2'd1;
  localparam logic [1:0] MODE_SHARPEN = 2'd2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 1'd1;

  localparam int unsigned NUM_JOBS  = 4;
  localparam int unsigned JOB_IDX_W = 2;
  localparam int unsigned NUM_WIN   = 4;

  typedef struct packed {
    srf_kind_e kind;
    logic      sel;   // 0: taps q0..q3, 1: taps q1,q2,q3,q3
    logic      last;
  } srf_job_t;

  typedef struct packed {
    srf_pixel_t [NUM_WIN-1:0] pix;
    srf_job_t [NUM_JOBS-1:0]  jobs;
    logic [JOB_IDX_W:0]       njobs;
  } srf_rec_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       in_last;
  } srf_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_last;
  } srf_out_t;

endpackage

/* design/srf_lane.sv */
// One channel lane: evaluates the selected kernel on four 8-bit taps and clamps.
// Depends on srf_pkg.
module srf_lane (
  input  logic [7:0]         a_i,
  input  logic [7:0]         b_i,
  input  logic [7:0]         c_i,
  input  logic [7:0]         d_i,
  input  srf_pkg::srf_kind_e kind_i,
  output logic [7:0]         res_o
);
  import srf_pkg::*;

  logic signed [11:0] ea, eb, ec, ed, sum_s;
  logic [8:0]         scaled;

  assign ea = signed'({4'b0, a_i});
  assign eb = signed'({4'b0, b_i});
  assign ec = signed'({4'b0, c_i});
  assign ed = signed'({4'b0, d_i});

  // tap roles: prev = b, center = c, next = d; the halve kernel also uses a
  always_comb begin
    unique case (kind_i)
      KIND_HALF:      sum_s = ea + (eb <<< 1) + eb + (ec <<< 1) + ec + ed + 12'sd4;
      KIND_DBL_LEFT:  sum_s = (ec <<< 1) + ec + eb + 12'sd2;
      KIND_DBL_RIGHT: sum_s = (ec <<< 1) + ec + ed + 12'sd2;
      KIND_SHARP:     sum_s = (ec <<< 2) + (ec <<< 1) - eb - ed + 12'sd2;
      default:        sum_s = '0;
    endcase
  end

  assign scaled = (kind_i == KIND_HALF) ? {1'b0, sum_s[10:3]} : sum_s[10:2];
  assign res_o  = sum_s[11] ? 8'd0 : (scaled[8] ? 8'hFF : scaled[7:0]);

endmodule

/* design/srf_window.sv */
// Span window: edge replication, span position tracking and result planning.
// Depends on srf_pkg; feeds at most one record per accepted beat to srf_emitter.
module srf_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  srf_pkg::srf_pixel_t pix_i,
  input  logic                last_i,
  input  logic [1:0]          mode_i,
  output srf_pkg::srf_rec_t   rec_o,
  output logic                push_o
);
  import srf_pkg::*;

  srf_pixel_t [2:0]         win_q;
  logic [1:0]               seen_q;
  logic                     parity_q;
  logic                     first;
  srf_pixel_t [NUM_WIN-1:0] q;
  srf_job_t [NUM_JOBS-1:0]  jobs;
  logic [JOB_IDX_W:0]       n;

  assign first = (seen_q == 2'd0);
  assign q[0]  = first ? pix_i : win_q[0];
  assign q[1]  = first ? pix_i : win_q[1];
  assign q[2]  = first ? pix_i : win_q[2];
  assign q[3]  = pix_i;

  always_comb begin
    jobs = '0;
    n    = '0;
    unique case (mode_i)
      MODE_HALVE: begin
        if (!parity_q && seen_q >= 2'd2) begin
          jobs[n[JOB_IDX_W-1:0]] = '{kind: KIND_HALF, sel: 1'b0, last: last_i};
          n = n + 3'd1;
        end
        if (last_i && parity_q) begin
          jobs[n[JOB_IDX_W-1:0]] = '{kind: KIND_HALF, sel: 1'b1, last: 1'b1};
          n = n + 3'd1;
        end
      end
      MODE_DOUBLE: begin
        if (!first) begin
          jobs[0] = '{kind: KIND_DBL_LEFT,  sel: 1'b0, last: 1'b0};
          jobs[1] = '{kind: KIND_DBL_RIGHT, sel: 1'b0, last: 1'b0};
          n = 3'd2;
        end
        if (last_i) begin
          jobs[n[JOB_IDX_W-1:0]] = '{kind: KIND_DBL_LEFT, sel: 1'b1, last: 1'b0};
          jobs[n[JOB_IDX_W-1:0] + 2'd1] = '{kind: KIND_DBL_RIGHT, sel: 1'b1, last: 1'b1};
          n = n + 3'd2;
        end
      end
      default: begin
        // sharpen, also the unused mode code
        if (!first) begin
          jobs[0] = '{kind: KIND_SHARP, sel: 1'b0, last: 1'b0};
          n = 3'd1;
        end
        if (last_i) begin
          jobs[n[JOB_IDX_W-1:0]] = '{kind: KIND_SHARP, sel: 1'b1, last: 1'b1};
          n = n + 3'd1;
        end
      end
    endcase
  end

  always_comb begin
    rec_o.pix   = q;
    rec_o.jobs  = jobs;
    rec_o.njobs = n;
  end

  assign push_o = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      seen_q   <= 2'd0;
      parity_q <= 1'b0;
    end else if (accept_i) begin
      win_q[0] <= q[1];
      win_q[1] <= q[2];
      win_q[2] <= pix_i;
      if (last_i) begin
        seen_q   <= 2'd0;
        parity_q <= 1'b0;
      end else begin
        if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
        parity_q <= ~parity_q;
      end
    end
  end

endmodule

/* design/srf_emitter.sv */
// Result emitter: two-entry record queue, job sequencer, four channel lanes,
// merge into the output register. Depends on srf_pkg and srf_lane.
module srf_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  srf_pkg::srf_rec_t rec_i,
  input  logic              alpha_en_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srf_pkg::srf_out_t out_data_o
);
  import srf_pkg::*;

  srf_rec_t             rec_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q, cnt_d;
  logic [JOB_IDX_W-1:0] job_idx_q;
  logic                 out_valid_q;
  srf_out_t             out_q, out_d;

  srf_rec_t   head;
  srf_job_t   job;
  logic       out_ready, issue, pop;
  srf_pixel_t pa, pb, pc, pd;
  logic [7:0] lane_res [4];

  assign head      = rec_q[rd_ptr_q];
  assign job       = head.jobs[job_idx_q];
  assign out_ready = !out_valid_q || !out_stall_i;
  assign issue     = (cnt_q != 2'd0) && out_ready;
  assign pop       = issue && ({1'b0, job_idx_q} == (head.njobs - 3'd1));
  assign full_o    = (cnt_q == 2'd2);
  assign cnt_d     = cnt_q + {1'b0, push_i} - {1'b0, pop};

  always_comb begin
    if (job.sel) begin
      pa = head.pix[1];
      pb = head.pix[2];
      pc = head.pix[3];
      pd = head.pix[3];
    end else begin
      pa = head.pix[0];
      pb = head.pix[1];
      pc = head.pix[2];
      pd = head.pix[3];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    srf_lane u_lane (
      .a_i    (pa[8*c +: 8]),
      .b_i    (pb[8*c +: 8]),
      .c_i    (pc[8*c +: 8]),
      .d_i    (pd[8*c +: 8]),
      .kind_i (job.kind),
      .res_o  (lane_res[c])
    );
  end

  always_comb begin
    out_d.out_red   = lane_res[0];
    out_d.out_green = lane_res[1];
    out_d.out_blue  = lane_res[2];
    out_d.out_alpha = alpha_en_i ? lane_res[3] : 8'd0;
    out_d.out_last  = job.last;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) rec_q[wr_ptr_q] <= rec_i;
    if (issue) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      cnt_q       <= 2'd0;
      job_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q  <= ~rd_ptr_q;
        job_idx_q <= '0;
      end else if (issue) begin
        job_idx_q <= job_idx_q + 2'd1;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/span_resample_filter_unit.sv */
// Span resample filter top: takes one RGBA8 pixel per beat and, while the
// output is not stalled, issues one filtered pixel per cycle from a
// registered output fed through the record queue; halve and sharpen then
// sustain one source pixel per cycle. Double makes two results per source
// pixel, paced by the emitter producing one result per cycle. A span end can
// add up to two extra results, absorbed by a two-entry record queue. Config
// writes are always accepted. Depends on srf_pkg, srf_window, srf_emitter.
module span_resample_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  srf_pkg::srf_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output srf_pkg::srf_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import srf_pkg::*;

  logic [1:0] mode_q;
  logic       alpha_en_q;
  logic       in_fire, full, push;
  srf_pixel_t pix;
  srf_rec_t   rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HALVE;
      alpha_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FILTER_MODE:  mode_q     <= cfg_data_i;
        REG_ALPHA_ENABLE: alpha_en_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign pix = {in_data_i.in_alpha, in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};

  srf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .pix_i    (pix),
    .last_i   (in_data_i.in_last),
    .mode_i   (mode_q),
    .rec_o    (rec),
    .push_o   (push)
  );

  srf_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec_i       (rec),
    .alpha_en_i  (alpha_en_q),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/srf_checker.sv */
// Port-level checks of the span resample filter, bound to the top level.
// Depends on srf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input srf_pkg::srf_out_t out_data_o
);
  import srf_pkg::*;

  `SRF_ASSERT(a_out_hold_valid, out_valid_o && out_stall_i |=> out_valid_o)
  `SRF_ASSERT(a_out_hold_data, out_valid_o && out_stall_i |=> $stable(out_data_o))
  `SRF_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o)
  // idle output and no beat taken: nothing can be queued
  `SRF_ASSERT(a_no_spurious_out, !out_valid_o && !$past(in_valid_i && !in_stall_o) |=> !out_valid_o)

endmodule

bind span_resample_filter_unit srf_checker u_srf_checker (.*);
